[hw/rtl/multilevel_priority_task_scheduler_defines.svh]
// Assertion macros shared by the scheduler RTL.
// Depends on clk_i and rst_ni being visible where the macros are used.
`ifndef MULTILEVEL_PRIORITY_TASK_SCHEDULER_DEFINES_SVH
`define MULTILEVEL_PRIORITY_TASK_SCHEDULER_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define MLPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define MLPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[hw/rtl/mlps_pkg.sv]
// Shared types and constants for the multilevel priority task scheduler.
// No dependencies.
package mlps_pkg;

  localparam int MAX_TASKS_DEF       = 64;
  localparam int PRIORITY_LEVELS_DEF = 10;
  localparam int LIST_W              = 5;
  localparam int PROTECTED_ID        = 1;

  localparam logic [2:0] CMD_ADD     = 3'd0;
  localparam logic [2:0] CMD_TICK    = 3'd1;
  localparam logic [2:0] CMD_BLOCK   = 3'd2;
  localparam logic [2:0] CMD_UNBLOCK = 3'd3;
  localparam logic [2:0] CMD_KILL    = 3'd4;
  localparam logic [2:0] CMD_SETPRIO = 3'd5;

  localparam logic [1:0] RS_OK        = 2'd0;
  localparam logic [1:0] RS_NOT_FOUND = 2'd1;
  localparam logic [1:0] RS_BAD_PRIO  = 2'd2;
  localparam logic [1:0] RS_PROTECTED = 2'd3;

  localparam logic CFG_MODE_IDX = 1'b0;

  typedef enum logic [1:0] {
    TS_FREE    = 2'd0,
    TS_READY   = 2'd1,
    TS_BLOCKED = 2'd2,
    TS_RUNNING = 2'd3
  } task_st_e;

  typedef struct packed {
    task_st_e          st;
    logic [3:0]        qn;
    logic [3:0]        pri;
    logic [LIST_W-1:0] lst;
  } ent_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_EXEC,
    ST_UNL,
    ST_POP,
    ST_WALK,
    ST_FIX,
    ST_POST,
    ST_RESCH,
    ST_CURRD,
    ST_DISP,
    ST_DISP2,
    ST_DONE
  } fsm_e;

endpackage

[hw/rtl/mlps_ram.sv]
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module mlps_ram #(
  parameter int W = 8,
  parameter int D = 64
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);
  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  // Write, then read through an output register
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

[hw/rtl/multilevel_priority_task_scheduler.sv]
// Top level of the multilevel priority task scheduler: command sequencer,
// list heads and tails, task table and link memories. Uses mlps_pkg, mlps_ram and the defines header.
//
//  channel  | ports                                         | transfer when
//  ---------+-----------------------------------------------+----------------------
//  command  | start, command_i, task_id_i, priority_req_i   | start && !busy
//  result   | done_o, running_task_o, running_valid_o, ...  | done_o (one cycle)
//  config   | psel, penable, pwrite, paddr, pwdata, prdata  | psel&&penable&&pwrite
//
// Unlinking a task that is not at the head of its list walks the list, each walk
// step one read of the link memory. Reset clears the list flags, the running task
// and the per-entry valid bits at once; no clearing pass. The result strobe lasts
// one cycle and cannot be stalled; busy stays high until the cycle after the strobe.
module multilevel_priority_task_scheduler #(
  parameter int MAX_TASKS       = mlps_pkg::MAX_TASKS_DEF,
  parameter int PRIORITY_LEVELS = mlps_pkg::PRIORITY_LEVELS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  command_i,
  input  logic [5:0]  task_id_i,
  input  logic [3:0]  priority_req_i,
  output logic        done_o,
  output logic [5:0]  running_task_o,
  output logic        running_valid_o,
  output logic [1:0]  status_o,
  output logic        switched_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mlps_pkg::*;

  localparam int TW    = $clog2(MAX_TASKS);
  localparam int NL    = PRIORITY_LEVELS + 2;
  localparam int LIW   = $clog2(NL);
  localparam int PLAIN = PRIORITY_LEVELS;
  localparam int BLK   = PRIORITY_LEVELS + 1;
  localparam int EW    = $bits(ent_t);

  fsm_e            state_q, state_d;
  logic [2:0]      cmd_q, cmd_d;
  logic [5:0]      tid_q, tid_d;
  logic [3:0]      pr_q, pr_d;
  logic [1:0]      res_q, res_d;
  logic [TW-1:0]   cur_q, cur_d;
  logic            curv_q, curv_d;
  logic [TW-1:0]   wast_q, wast_d;
  logic            wasv_q, wasv_d;
  logic            mode_q;
  ent_t            ent_q, ent_d;
  logic [TW-1:0]   wprev_q, wprev_d;
  logic [LIW-1:0]  wl_q, wl_d;
  logic [LIW-1:0]  pk_q, pk_d;
  logic [TW-1:0]   head_q [NL];
  logic [TW-1:0]   head_d [NL];
  logic [TW-1:0]   tail_q [NL];
  logic [TW-1:0]   tail_d [NL];
  logic [NL-1:0]   lv_q, lv_d;
  logic [MAX_TASKS-1:0] tvalid_q;
  logic            trv_q;

  // Memory ports
  logic            twe;
  logic [TW-1:0]   twa, tra;
  ent_t            twd;
  logic [EW-1:0]   trd_raw;
  ent_t            ent_rd;
  logic            lwe;
  logic [TW-1:0]   lwa, lwd, lra, lrd;

  logic            cfg_wr;
  logic [TW-1:0]   tix;

  mlps_ram #(.W(EW), .D(MAX_TASKS)) u_task_ram (
    .clk_i   (clk_i),
    .we_i    (twe),
    .waddr_i (twa),
    .wdata_i (twd),
    .raddr_i (tra),
    .rdata_o (trd_raw)
  );

  mlps_ram #(.W(TW), .D(MAX_TASKS)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (lwe),
    .waddr_i (lwa),
    .wdata_i (lwd),
    .raddr_i (lra),
    .rdata_o (lrd)
  );

  // Entries never written read as free with zero quantum
  assign ent_rd = trv_q ? ent_t'(trd_raw) : '0;
  assign tix    = TW'(tid_q);

  // Ready list for a task of a given priority
  function automatic logic [LIW-1:0] lst_for(input logic m, input logic [3:0] p);
    logic [LIW-1:0] r;
    r = LIW'(PLAIN);
    if (m && p != 4'd0 && 32'(p) <= PRIORITY_LEVELS) begin
      r = LIW'(p - 4'd1);
    end
    return r;
  endfunction

  // Configuration port
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == CFG_MODE_IDX) ? {31'd0, mode_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1;
    end else if (cfg_wr && paddr[2] == CFG_MODE_IDX) begin
      mode_q <= pwdata[0];
    end
  end

  // Sequencer: next state, list updates and memory accesses
  always_comb begin
    logic            psh_en;
    logic [LIW-1:0]  psh_l;
    logic [TW-1:0]   psh_id;
    ent_t            psh_ent;
    ent_t            e;
    logic [LIW-1:0]  li;
    logic [LIW-1:0]  pk;
    logic            found;
    logic [TW-1:0]   h;
    logic [3:0]      nq;
    logic            prio_ok;

    state_d = state_q;
    cmd_d   = cmd_q;
    tid_d   = tid_q;
    pr_d    = pr_q;
    res_d   = res_q;
    cur_d   = cur_q;
    curv_d  = curv_q;
    wast_d  = wast_q;
    wasv_d  = wasv_q;
    ent_d   = ent_q;
    wprev_d = wprev_q;
    wl_d    = wl_q;
    pk_d    = pk_q;
    head_d  = head_q;
    tail_d  = tail_q;
    lv_d    = lv_q;
    twe     = 1'b0;
    twa     = tix;
    twd     = ent_q;
    tra     = tix;
    lwe     = 1'b0;
    lwa     = wprev_q;
    lwd     = lrd;
    lra     = lrd;
    psh_en  = 1'b0;
    psh_l   = LIW'(BLK);
    psh_id  = tix;
    psh_ent = ent_q;
    e       = ent_rd;
    li      = LIW'(ent_q.lst);
    pk      = '0;
    found   = 1'b0;
    h       = head_q[pk_q];
    nq      = 4'd0;
    prio_ok = pr_q != 4'd0 && 32'(pr_q) <= PRIORITY_LEVELS;

    case (state_q)
      ST_IDLE: begin
        tra = TW'(task_id_i);
        if (start) begin
          cmd_d   = command_i;
          tid_d   = task_id_i;
          pr_d    = priority_req_i;
          res_d   = RS_OK;
          wasv_d  = curv_q;
          wast_d  = cur_q;
          state_d = ST_LOAD;
        end
      end

      ST_LOAD: begin
        ent_d   = ent_rd;
        state_d = ST_EXEC;
      end

      // Decode the command against the target task's entry
      ST_EXEC: begin
        state_d = ST_DISP;
        if (cmd_q > CMD_SETPRIO) begin
          state_d = ST_DISP;
        end else if (32'(tid_q) >= MAX_TASKS) begin
          res_d = RS_NOT_FOUND;
        end else begin
          case (cmd_q)
            CMD_ADD: begin
              if (!prio_ok) begin
                res_d = RS_BAD_PRIO;
              end else if (ent_q.st == TS_FREE) begin
                psh_en  = 1'b1;
                psh_l   = lst_for(mode_q, pr_q);
                psh_ent = '{st: TS_READY, qn: 4'd0, pri: pr_q, lst: '0};
              end
            end
            CMD_TICK: begin
              if (curv_q) state_d = ST_RESCH;
            end
            CMD_BLOCK: begin
              if (curv_q && cur_q == tix) begin
                curv_d     = 1'b0;
                psh_en     = 1'b1;
                psh_ent.st = TS_BLOCKED;
              end else if (ent_q.st == TS_FREE) begin
                res_d = RS_NOT_FOUND;
              end else if (tid_q == 6'(PROTECTED_ID)) begin
                res_d = RS_PROTECTED;
              end else begin
                state_d = ST_UNL;
              end
            end
            CMD_UNBLOCK: begin
              if (ent_q.st != TS_BLOCKED) res_d = RS_NOT_FOUND;
              else state_d = ST_UNL;
            end
            CMD_KILL: begin
              if (tid_q == 6'(PROTECTED_ID)) begin
                res_d = RS_PROTECTED;
              end else if (ent_q.st == TS_FREE) begin
                res_d = RS_NOT_FOUND;
              end else if (curv_q && cur_q == tix) begin
                curv_d = 1'b0;
                twe    = 1'b1;
                twd    = ent_q;
                twd.st = TS_FREE;
              end else begin
                state_d = ST_UNL;
              end
            end
            CMD_SETPRIO: begin
              if (!prio_ok) begin
                res_d = RS_BAD_PRIO;
              end else if (ent_q.st == TS_FREE) begin
                res_d = RS_NOT_FOUND;
              end else if (mode_q) begin
                ent_d.pri = pr_q;
                if (ent_q.st == TS_RUNNING) begin
                  twe     = 1'b1;
                  twd     = ent_q;
                  twd.pri = pr_q;
                end else begin
                  state_d = ST_UNL;
                end
              end
            end
            default: state_d = ST_DISP;
          endcase
        end
      end

      // Unlink the target task: check the head of its list
      ST_UNL: begin
        state_d = ST_POST;
        if (32'(ent_q.lst) < NL) begin
          if (lv_q[li]) begin
            wl_d = li;
            if (head_q[li] == tix) begin
              if (head_q[li] == tail_q[li]) begin
                lv_d[li] = 1'b0;
              end else begin
                lra     = tix;
                state_d = ST_POP;
              end
            end else if (head_q[li] != tail_q[li]) begin
              wprev_d = head_q[li];
              lra     = head_q[li];
              state_d = ST_WALK;
            end
          end
        end
      end

      // Advance the head past the removed task
      ST_POP: begin
        head_d[wl_q] = lrd;
        state_d      = ST_POST;
      end

      // Walk the list one link per cycle
      ST_WALK: begin
        if (lrd == tix) begin
          lra     = tix;
          state_d = ST_FIX;
        end else if (lrd == tail_q[wl_q]) begin
          state_d = ST_POST;
        end else begin
          wprev_d = lrd;
          lra     = lrd;
        end
      end

      // Bypass the removed task
      ST_FIX: begin
        lwe = 1'b1;
        lwa = wprev_q;
        lwd = lrd;
        if (tail_q[wl_q] == tix) tail_d[wl_q] = wprev_q;
        state_d = ST_POST;
      end

      // Requeue the target after it left its list, or free it on a kill
      ST_POST: begin
        state_d = ST_DISP;
        case (cmd_q)
          CMD_BLOCK: begin
            psh_en     = 1'b1;
            psh_ent.st = TS_BLOCKED;
          end
          CMD_UNBLOCK: begin
            psh_en     = 1'b1;
            psh_l      = lst_for(mode_q, ent_q.pri);
            psh_ent.st = TS_READY;
            psh_ent.qn = 4'd0;
            state_d    = ST_RESCH;
          end
          CMD_KILL: begin
            twe    = 1'b1;
            twd    = ent_q;
            twd.st = TS_FREE;
          end
          CMD_SETPRIO: begin
            psh_en = 1'b1;
            if (ent_q.st == TS_READY) begin
              psh_l      = lst_for(mode_q, ent_q.pri);
              psh_ent.qn = 4'd0;
            end
          end
          default: state_d = ST_DISP;
        endcase
      end

      ST_RESCH: begin
        tra     = cur_q;
        state_d = curv_q ? ST_CURRD : ST_DISP;
      end

      // Requeue the running task, aging it on a tick
      ST_CURRD: begin
        if (cmd_q == CMD_TICK) begin
          nq = (e.qn == 4'hF) ? 4'hF : e.qn + 4'd1;
          if (mode_q && nq >= e.pri && e.pri > 4'd1) e.pri = e.pri - 4'd1;
        end
        psh_en  = 1'b1;
        psh_id  = cur_q;
        psh_l   = lst_for(mode_q, e.pri);
        psh_ent = '{st: TS_READY, qn: 4'd0, pri: e.pri, lst: '0};
        curv_d  = 1'b0;
        state_d = ST_DISP;
      end

      // Pick the preferred non-empty ready list
      ST_DISP: begin
        state_d = ST_DONE;
        if (!curv_q) begin
          if (!mode_q && lv_q[PLAIN]) begin
            pk    = LIW'(PLAIN);
            found = 1'b1;
          end else begin
            for (int l = 0; l < PRIORITY_LEVELS; l++) begin
              if (lv_q[l]) begin
                pk    = LIW'(l);
                found = 1'b1;
              end
            end
            if (!found && lv_q[PLAIN]) begin
              pk    = LIW'(PLAIN);
              found = 1'b1;
            end
          end
          if (found) begin
            pk_d    = pk;
            tra     = head_q[pk];
            lra     = head_q[pk];
            state_d = ST_DISP2;
          end
        end
      end

      // Pop the head and mark it running
      ST_DISP2: begin
        if (head_q[pk_q] == tail_q[pk_q]) lv_d[pk_q] = 1'b0;
        else head_d[pk_q] = lrd;
        twe     = 1'b1;
        twa     = h;
        twd     = ent_rd;
        twd.st  = TS_RUNNING;
        cur_d   = h;
        curv_d  = 1'b1;
        state_d = ST_DONE;
      end

      ST_DONE: state_d = ST_IDLE;

      default: state_d = ST_IDLE;
    endcase

    // Append a task to the tail of a list
    if (psh_en) begin
      if (lv_q[psh_l]) begin
        lwe = 1'b1;
        lwa = tail_q[psh_l];
        lwd = psh_id;
      end else begin
        head_d[psh_l] = psh_id;
        lv_d[psh_l]   = 1'b1;
      end
      tail_d[psh_l] = psh_id;
      twe           = 1'b1;
      twa           = psh_id;
      twd           = psh_ent;
      twd.lst       = LIST_W'(psh_l);
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      curv_q   <= 1'b0;
      lv_q     <= '0;
      tvalid_q <= '0;
    end else begin
      state_q <= state_d;
      curv_q  <= curv_d;
      lv_q    <= lv_d;
      if (twe) tvalid_q[twa] <= 1'b1;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    tid_q   <= tid_d;
    pr_q    <= pr_d;
    res_q   <= res_d;
    cur_q   <= cur_d;
    wast_q  <= wast_d;
    wasv_q  <= wasv_d;
    ent_q   <= ent_d;
    wprev_q <= wprev_d;
    wl_q    <= wl_d;
    pk_q    <= pk_d;
    head_q  <= head_d;
    tail_q  <= tail_d;
    trv_q   <= tvalid_q[tra];
  end

  // Result
  assign busy            = state_q != ST_IDLE;
  assign done_o          = state_q == ST_DONE;
  assign running_task_o  = curv_q ? 6'(cur_q) : 6'd0;
  assign running_valid_o = curv_q;
  assign status_o        = res_q;
  assign switched_o      = (wasv_q != curv_q) || (curv_q && wast_q != cur_q);

`include "multilevel_priority_task_scheduler_defines.svh"

  `MLPS_ASSERT(a_done_one_cycle, done_o |=> !done_o, "result strobe longer than one cycle")
  `MLPS_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted command did not raise busy")
  `MLPS_ASSERT(a_idle_dispatched, (done_o && !curv_q) |-> (lv_q[PLAIN:0] == '0), "ready task left undispatched")
  `MLPS_ASSERT_ALWAYS(a_pready, pready, "pready dropped")
endmodule
